### design/krts_pkg.sv
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared types, constants and codes for the keyed record table with sort.
// ----------------------------------------------------------------------------
`default_nettype none

package krts_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned IdW        = 32;
  localparam int unsigned DeptW      = 2;
  localparam int unsigned RecW       = IdW + DeptW;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_MODIFY = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_SORT   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_DEPT  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        action;
    logic signed [31:0] key_id;
    logic signed [31:0] new_id;
    logic [1:0]        new_department;
    logic              descending;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [1:0] found_department;
    logic [6:0] stored_count;
  } rsp_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,       // nothing
    DP_LATCH,     // capture request, clear match and position
    DP_RD,        // read entry at command address
    DP_SCAN_STEP, // compare data against key, advance scan
    DP_WR_NEW,    // write key/new record at write address
    DP_SHIFT_RD,  // read entry pos+1
    DP_SHIFT_WR,  // write entry pos, advance
    DP_SEL_INIT,  // pick = i, j = i+1
    DP_SEL_STEP,  // compare entry j with pick
    DP_SWAP_RD,   // read entry i
    DP_SWAP_W1,   // write pick record at i
    DP_SWAP_W2    // write old i record at pick
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [IdxW-1:0] addr;    // memory address for reads/writes
    logic       use_new;      // write uses new_id instead of key_id
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
  } dp_cmd_t;

endpackage

`default_nettype wire

### design/krts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module krts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### design/krts_ctrl.sv
// ----------------------------------------------------------------------------
// Keyed record table controller
// Sequences lookup, shift, write and selection sort over the table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module krts_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [2:0]              action_i,
  input  wire logic [1:0]              new_department_i,
  input  wire logic [krts_pkg::CntW-1:0] count_i,
  input  wire logic                    match_i,      // registered scan hit
  input  wire logic [krts_pkg::IdxW-1:0] pos_i,      // first match index
  input  wire logic [krts_pkg::IdxW-1:0] pick_i,
  output krts_pkg::dp_cmd_t            cmd_o,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic                         idx_valid_o,
  output logic                         dept_valid_o
);
  import krts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_SHIFT_RD, S_SHIFT_WAIT,
    S_SHIFT_WR, S_SEL_INIT, S_SEL_RD, S_SEL_CMP, S_SWAP_RD, S_SWAP_W1,
    S_SWAP_W2, S_DONE
  } state_e;

  state_e state_q;
  logic [2:0] act_q;
  logic [1:0] dept_q;
  logic [CntW-1:0] scan_q;   // scan, shift and outer sort index
  logic [CntW-1:0] j_q;      // inner sort index
  logic [2:0] st_q;
  logic       iv_q, dv_q;

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign status_o     = st_q;
  assign idx_valid_o  = iv_q;
  assign dept_valid_o = dv_q;

  // Commands decoded from the state.
  always_comb begin
    cmd_o = '0;
    cmd_o.op = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_LATCH;
          // Clear empties the table as the item is taken.
          cmd_o.cnt_clr = (action_i == ACT_CLEAR);
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = DP_RD;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_SCAN_CMP: begin
        cmd_o.op = DP_SCAN_STEP;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_DECIDE: begin
        if (act_q == ACT_ADD && dept_q != 2'd0 && !match_i &&
            count_i < CntW'(TableDepth)) begin
          cmd_o.op = DP_WR_NEW;
          cmd_o.addr = count_i[IdxW-1:0];
          cmd_o.cnt_inc = 1'b1;
        end else if (act_q == ACT_MODIFY && match_i && dept_q != 2'd0) begin
          cmd_o.op = DP_WR_NEW;
          cmd_o.addr = pos_i;
          cmd_o.use_new = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.op = DP_SHIFT_RD;
        cmd_o.addr = IdxW'(scan_q + 1'b1);
        // The last shift step drops the count before the result goes out.
        cmd_o.cnt_dec = !(scan_q + 1'b1 < count_i);
      end
      S_SHIFT_WAIT: begin
        // Keep the read address so the next entry is still on the read port.
        cmd_o.op = DP_RD;
        cmd_o.addr = IdxW'(scan_q + 1'b1);
      end
      S_SHIFT_WR: begin
        cmd_o.op = DP_SHIFT_WR;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_SEL_INIT: begin
        cmd_o.op = DP_SEL_INIT;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_SEL_RD: begin
        cmd_o.op = DP_RD;
        cmd_o.addr = j_q[IdxW-1:0];
      end
      S_SEL_CMP: begin
        cmd_o.op = DP_SEL_STEP;
        cmd_o.addr = j_q[IdxW-1:0];
      end
      S_SWAP_RD: begin
        cmd_o.op = DP_SWAP_RD;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_SWAP_W1: begin
        cmd_o.op = DP_SWAP_W1;
        cmd_o.addr = scan_q[IdxW-1:0];
      end
      S_SWAP_W2: begin
        cmd_o.op = DP_SWAP_W2;
        cmd_o.addr = pick_i;
      end
      default: ;
    endcase
  end

  // State and registered result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
      dept_q  <= '0;
      scan_q  <= '0;
      j_q     <= '0;
      st_q    <= ST_OK;
      iv_q    <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            act_q  <= action_i;
            dept_q <= new_department_i;
            scan_q <= '0;
            st_q   <= ST_OK;
            iv_q   <= 1'b0;
            dv_q   <= 1'b0;
            if (action_i inside {ACT_ADD, ACT_DELETE, ACT_MODIFY, ACT_FIND}) begin
              state_q <= (action_i == ACT_ADD && new_department_i == 2'd0) ?
                         S_DECIDE : S_SCAN_RD;
            end else if (action_i == ACT_SORT) begin
              state_q <= S_SEL_INIT;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SCAN_RD: begin
          state_q <= (scan_q < count_i) ? S_SCAN_CMP : S_DECIDE;
        end
        S_SCAN_CMP: begin
          scan_q  <= scan_q + 1'b1;
          state_q <= S_SCAN_RD;
        end
        S_DECIDE: begin
          state_q <= S_DONE;
          case (act_q)
            ACT_ADD: begin
              if (dept_q == 2'd0) begin
                st_q <= ST_BAD_DEPT;
              end else if (match_i) begin
                st_q <= ST_DUPLICATE;
              end else if (count_i >= CntW'(TableDepth)) begin
                st_q <= ST_FULL;
              end else begin
                iv_q <= 1'b1;
              end
            end
            ACT_DELETE: begin
              if (!match_i) begin
                st_q <= ST_NOT_FOUND;
              end else begin
                iv_q    <= 1'b1;
                scan_q  <= CntW'(pos_i);
                state_q <= S_SHIFT_RD;
              end
            end
            ACT_MODIFY: begin
              if (!match_i) begin
                st_q <= ST_NOT_FOUND;
              end else if (dept_q == 2'd0) begin
                st_q <= ST_BAD_DEPT;
              end else begin
                iv_q <= 1'b1;
              end
            end
            default: begin
              if (!match_i) begin
                st_q <= ST_NOT_FOUND;
              end else begin
                iv_q <= 1'b1;
                dv_q <= 1'b1;
              end
            end
          endcase
        end
        S_SHIFT_RD: begin
          state_q <= (scan_q + 1'b1 < count_i) ? S_SHIFT_WAIT : S_DONE;
        end
        S_SHIFT_WAIT: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          scan_q  <= scan_q + 1'b1;
          state_q <= S_SHIFT_RD;
        end
        S_SEL_INIT: begin
          j_q     <= scan_q + 1'b1;
          state_q <= (scan_q < count_i) ? S_SEL_RD : S_DONE;
        end
        S_SEL_RD: begin
          state_q <= (j_q < count_i) ? S_SEL_CMP : S_SWAP_RD;
        end
        S_SEL_CMP: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_SEL_RD;
        end
        S_SWAP_RD: begin
          state_q <= S_SWAP_W1;
        end
        S_SWAP_W1: begin
          state_q <= S_SWAP_W2;
        end
        S_SWAP_W2: begin
          scan_q  <= scan_q + 1'b1;
          state_q <= S_SEL_INIT;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result strobe is always followed by a return to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("done not followed by idle");
  // Department is reported only with an index.
  a_dept_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> iv_q) else $error("department without index");
  // An index is reported only with status ok.
  a_idx_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && iv_q) |-> st_q == ST_OK) else $error("index with error status");
`endif

endmodule

`default_nettype wire

### design/krts_dp.sv
// ----------------------------------------------------------------------------
// Keyed record table datapath
// Table memory, record count, key compare and selection-sort pick register.
// ----------------------------------------------------------------------------
`default_nettype none

module krts_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  krts_pkg::req_t                 req_i,
  input  krts_pkg::dp_cmd_t              cmd_i,
  output logic [krts_pkg::CntW-1:0]      count_o,
  output logic                           match_o,
  output logic [krts_pkg::IdxW-1:0]      pos_o,
  output logic [krts_pkg::IdxW-1:0]      pick_o,
  output logic [1:0]                     dept_o
);
  import krts_pkg::*;

  req_t            req_q;
  logic [CntW-1:0] count_q;
  logic            match_q;
  logic [IdxW-1:0] pos_q;
  logic [IdxW-1:0] pick_q;
  logic [RecW-1:0] pick_rec_q;
  logic [RecW-1:0] hold_q;
  logic [1:0]      dept_q;
  logic            seed_q;
  logic            we;
  logic [RecW-1:0] wdata;
  logic [RecW-1:0] rdata;
  logic signed [IdW-1:0] rd_id, pk_id;
  logic            better;

  assign rd_id  = rdata[RecW-1:DeptW];
  assign pk_id  = pick_rec_q[RecW-1:DeptW];
  assign better = req_q.descending ? (pk_id < rd_id) : (rd_id < pk_id);

  // Memory write select.
  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    case (cmd_i.op)
      DP_WR_NEW: begin
        we    = 1'b1;
        wdata = {(cmd_i.use_new ? req_q.new_id : req_q.key_id), req_q.new_department};
      end
      DP_SHIFT_WR: we = 1'b1;
      DP_SWAP_W1: begin
        we    = 1'b1;
        wdata = pick_rec_q;
      end
      DP_SWAP_W2: begin
        we    = 1'b1;
        wdata = hold_q;
      end
      default: ;
    endcase
  end

  krts_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (cmd_i.addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Scan, pick and request registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        req_q   <= req_i;
        match_q <= 1'b0;
        pos_q   <= '0;
        dept_q  <= '0;
      end
      DP_SCAN_STEP: begin
        if (!match_q && rd_id == req_q.key_id) begin
          match_q <= 1'b1;
          pos_q   <= cmd_i.addr;
          dept_q  <= rdata[DeptW-1:0];
        end
      end
      // The written position is the index reported for add and modify.
      DP_WR_NEW: pos_q <= cmd_i.addr;
      DP_SEL_INIT: pick_q <= cmd_i.addr;
      DP_SEL_STEP: begin
        if (better) begin
          pick_q <= cmd_i.addr;
        end
      end
      DP_SWAP_RD: ;
      DP_SWAP_W1: hold_q <= rdata;
      default: ;
    endcase
    // The entry at the outer index seeds the pick; a better entry replaces it.
    if (seed_q || (cmd_i.op == DP_SEL_STEP && better)) begin
      pick_rec_q <= rdata;
    end
  end

  // The record at the outer index, read during SEL_INIT, arrives on the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 1'b0;
    end else begin
      seed_q <= (cmd_i.op == DP_SEL_INIT);
    end
  end

  assign count_o = count_q;
  assign match_o = match_q;
  assign pos_o   = pos_q;
  assign pick_o  = pick_q;
  assign dept_o  = dept_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("count overflow");
  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> count_q < CntW'(TableDepth)) else $error("add when full");
  a_dec_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> count_q != '0) else $error("delete when empty");
`endif

endmodule

`default_nettype wire

### design/keyed_record_table_sort.sv
// Find, add, modify and delete scan the stored records; delete then shifts the
// later entries down; sort runs a selection sort over the stored records.
// Clear and unused actions go straight to the result. One request at a time, set by the
// single table memory port. Reset empties the table at once (count cleared).
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// Keyed record table with selection sort
// Top level: joins the controller and datapath and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_sort (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  krts_pkg::req_t   req_i,
  output logic             busy,
  output logic             done_o,
  output krts_pkg::rsp_t   rsp_o
);
  import krts_pkg::*;

  dp_cmd_t         cmd;
  logic [CntW-1:0] count;
  logic            match;
  logic [IdxW-1:0] pos, pick;
  logic [1:0]      dept;
  logic            done;
  logic [2:0]      status;
  logic            iv, dv;

  krts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i          (start),
    .action_i         (req_i.action),
    .new_department_i (req_i.new_department),
    .count_i          (count),
    .match_i          (match),
    .pos_i            (pos),
    .pick_i           (pick),
    .cmd_o            (cmd),
    .busy_o           (busy),
    .done_o           (done),
    .status_o         (status),
    .idx_valid_o      (iv),
    .dept_valid_o     (dv)
  );

  krts_dp u_dp (
    .clk_i, .rst_ni,
    .req_i   (req_i),
    .cmd_i   (cmd),
    .count_o (count),
    .match_o (match),
    .pos_o   (pos),
    .pick_o  (pick),
    .dept_o  (dept)
  );

  // Result register: count is already final in the done state.
  logic [IdxW-1:0] idx_sel;
  always_comb begin
    idx_sel = iv ? pos : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_o.status           <= status;
      rsp_o.found_index      <= 6'(idx_sel);
      rsp_o.found_department <= dv ? dept : 2'd0;
    end
    rsp_o.stored_count <= 7'(count);
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Keyed record table testbench
// Drives add, delete, modify, find, sort and clear requests into the table,
// keeps a shadow copy of the table to predict every response, and checks each
// response field by field as it is strobed out.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import krts_pkg::*;

  // Action codes that the block ignores.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam int         MaxReported = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  // Shadow table used to predict the responses.
  logic signed [31:0] shadow_ids [TableDepth];
  logic [1:0]         shadow_depts [TableDepth];
  int                 shadow_count = 0;

  rsp_t pending_rsps [$];
  int   fail_count = 0;
  int   idle_pct = 0;

  keyed_record_table_sort dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit, far above the slowest correct run.
  initial begin
    #10000000;
    $display("keyed_record_table_sort verification failed");
    $finish;
  end

  // Position of the first record with this ID, or -1.
  function automatic int shadow_lookup(logic signed [31:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns its response.
  function automatic rsp_t apply_request(req_t r);
    rsp_t rsp;
    int   pos;
    int   pick;
    logic signed [31:0] tid;
    logic [1:0] tdept;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.action)
      ACT_ADD: begin
        if (r.new_department == 2'd0) begin
          rsp.status = ST_BAD_DEPT;
        end else if (shadow_lookup(r.key_id) >= 0) begin
          rsp.status = ST_DUPLICATE;
        end else if (shadow_count >= TableDepth) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.found_index = 6'(shadow_count);
          shadow_ids[shadow_count] = r.key_id;
          shadow_depts[shadow_count] = r.new_department;
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        pos = shadow_lookup(r.key_id);
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.found_index = 6'(pos);
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_ids[i] = shadow_ids[i+1];
            shadow_depts[i] = shadow_depts[i+1];
          end
          shadow_count--;
        end
      end
      ACT_MODIFY: begin
        pos = shadow_lookup(r.key_id);
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else if (r.new_department == 2'd0) begin
          rsp.status = ST_BAD_DEPT;
        end else begin
          rsp.found_index = 6'(pos);
          shadow_ids[pos] = r.new_id;
          shadow_depts[pos] = r.new_department;
        end
      end
      ACT_FIND: begin
        pos = shadow_lookup(r.key_id);
        if (pos < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.found_index = 6'(pos);
          rsp.found_department = shadow_depts[pos];
        end
      end
      ACT_SORT: begin
        // Selection sort: the first extreme of the rest moves into place.
        for (int i = 0; i < shadow_count; i++) begin
          pick = i;
          for (int j = i + 1; j < shadow_count; j++) begin
            if (r.descending ? (shadow_ids[pick] < shadow_ids[j])
                             : (shadow_ids[j] < shadow_ids[pick])) pick = j;
          end
          tid = shadow_ids[i];
          shadow_ids[i] = shadow_ids[pick];
          shadow_ids[pick] = tid;
          tdept = shadow_depts[i];
          shadow_depts[i] = shadow_depts[pick];
          shadow_depts[pick] = tdept;
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    rsp.stored_count = 7'(shadow_count);
    return rsp;
  endfunction

  function automatic req_t make_req(logic [2:0] act, logic signed [31:0] key,
                                    logic signed [31:0] nid, logic [1:0] dept,
                                    logic desc);
    req_t r;
    r.action = act;
    r.key_id = key;
    r.new_id = nid;
    r.new_department = dept;
    r.descending = desc;
    return r;
  endfunction

  // Mostly IDs already stored or from a small pool, so lookups hit.
  function automatic logic signed [31:0] pick_id();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45 && shadow_count > 0) return shadow_ids[$urandom_range(0, shadow_count - 1)];
    if (sel < 75) return $signed($urandom_range(0, 12)) - 6;
    if (sel < 80) return {1'b1, 31'd0};
    if (sel < 85) return {1'b0, {31{1'b1}}};
    return $urandom;
  endfunction

  function automatic req_t random_req(int add_weight);
    int sel;
    logic [2:0] act;
    logic [1:0] dept;
    sel = $urandom_range(0, 99);
    if (sel < add_weight) act = ACT_ADD;
    else if (sel < add_weight + (96 - add_weight) / 4) act = ACT_DELETE;
    else if (sel < add_weight + (96 - add_weight) / 2) act = ACT_MODIFY;
    else if (sel < 93) act = ACT_FIND;
    else if (sel < 96) act = ACT_SORT;
    else if (sel < 98) act = ACT_CLEAR;
    else act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    dept = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    return make_req(act, pick_id(), pick_id(), dept, 1'($urandom));
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_req(req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsps.push_back(apply_request(r));
  endtask

  // Each strobed response is compared with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsps.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported)
          $display("unexpected response %h", rsp_o);
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (rsp_o.status !== exp_rsp.status ||
            rsp_o.found_index !== exp_rsp.found_index ||
            rsp_o.found_department !== exp_rsp.found_department ||
            rsp_o.stored_count !== exp_rsp.stored_count) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("mismatch: status %0d/%0d index %0d/%0d dept %0d/%0d count %0d/%0d",
                     exp_rsp.status, rsp_o.status, exp_rsp.found_index,
                     rsp_o.found_index, exp_rsp.found_department,
                     rsp_o.found_department, exp_rsp.stored_count,
                     rsp_o.stored_count);
        end
      end
    end
  end

  // Empty table: misses, sort and clear on nothing, spare actions.
  task automatic test_empty_table();
    send_req(make_req(ACT_FIND, 32'sd5, 32'sd0, 2'd1, 1'b0));
    send_req(make_req(ACT_DELETE, 32'sd5, 32'sd0, 2'd1, 1'b0));
    send_req(make_req(ACT_MODIFY, 32'sd5, 32'sd1, 2'd0, 1'b0));
    send_req(make_req(ACT_SORT, 32'sd0, 32'sd0, 2'd0, 1'b1));
    send_req(make_req(ACT_CLEAR, 32'sd0, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_SPARE_A, 32'sd0, 32'sd0, 2'd3, 1'b1));
  endtask

  // Add order of checks, extreme IDs, first match on repeated IDs.
  task automatic test_add_modify_find();
    send_req(make_req(ACT_ADD, {1'b1, 31'd0}, 32'sd0, 2'd3, 1'b0));
    send_req(make_req(ACT_ADD, {1'b0, {31{1'b1}}}, 32'sd0, 2'd1, 1'b0));
    send_req(make_req(ACT_ADD, -32'sd1, -32'sd1, 2'd2, 1'b1));
    send_req(make_req(ACT_ADD, -32'sd1, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_ADD, -32'sd1, 32'sd0, 2'd1, 1'b0));
    send_req(make_req(ACT_MODIFY, 32'sd7, 32'sd1, 2'd1, 1'b0));
    send_req(make_req(ACT_MODIFY, -32'sd1, 32'sd1, 2'd0, 1'b0));
    send_req(make_req(ACT_MODIFY, -32'sd1, {1'b1, 31'd0}, 2'd2, 1'b0));
    send_req(make_req(ACT_FIND, {1'b1, 31'd0}, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_FIND, {1'b0, {31{1'b1}}}, 32'sd0, 2'd0, 1'b0));
  endtask

  // Both sort orders with repeated IDs, then delete of the first match.
  task automatic test_sort_delete();
    send_req(make_req(ACT_SORT, 32'sd0, 32'sd0, 2'd0, 1'b1));
    send_req(make_req(ACT_FIND, {1'b1, 31'd0}, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_SORT, 32'sd0, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_DELETE, {1'b1, 31'd0}, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_FIND, {1'b1, 31'd0}, 32'sd0, 2'd0, 1'b0));
    send_req(make_req(ACT_SPARE_B, -32'sd1, -32'sd1, 2'd0, 1'b0));
    send_req(make_req(ACT_CLEAR, 32'sd0, 32'sd0, 2'd0, 1'b0));
  endtask

  // Random traffic; a high add weight drives the table to full.
  task automatic test_random_traffic(int n, int add_weight, int idle);
    idle_pct = idle;
    for (int k = 0; k < n; k++) send_req(random_req(add_weight));
  endtask

  task automatic finish_run();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_rsps.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_rsps.size() == 0) begin
      $display("keyed_record_table_sort verification clean");
    end else begin
      $display("keyed_record_table_sort verification failed");
    end
    $finish;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_add_modify_find();
    test_sort_delete();
    test_random_traffic(350, 35, 0);
    test_random_traffic(250, 80, 61);
    test_random_traffic(350, 30, 17);
    test_random_traffic(350, 45, 0);
    finish_run();
  end

endmodule

`default_nettype wire

### keyed_record_table_sort.f
design/krts_pkg.sv
design/krts_ram.sv
design/krts_ctrl.sv
design/krts_dp.sv
design/keyed_record_table_sort.sv
verif/testbench.sv
